>>> hdl/cptep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptep_pkg
// Shared widths, codes and types of the coverage premultiply tile pad block.
// ----------------------------------------------------------------------------
package cptep_pkg;

   // Default tile edge length in texels.
   localparam int TILE_DIM_DEFAULT = 64;

   // Field widths fixed by the interface.
   localparam int DATA_W  = 32;
   localparam int COV_W   = 17;
   localparam int COORD_W = 6;
   localparam int REGION_W = 7;
   localparam int OP_W    = 2;
   localparam int ENTRY_W = DATA_W + COV_W;

   // Coverage of one in Q1.16.
   localparam logic [COV_W-1:0] COV_ONE = 17'd65536;

   // Operation codes carried in the request tuser.
   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_FAIL = 2'd2;

   // Configuration register indexes.
   localparam logic REG_REGION_WIDTH  = 1'b0;
   localparam logic REG_REGION_HEIGHT = 1'b1;

   // Control of one pipeline stage.
   typedef struct packed {
      logic load;
      logic read;
      logic zero;
   } stage_type;

endpackage

>>> hdl/cptep_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptep_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cptep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cptep_premul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cptep_premul
// Coverage premultiply: registered product, then rounding and saturation.
// ----------------------------------------------------------------------------
module cptep_premul (
   input  logic                              clock,
   input  logic signed [cptep_pkg::DATA_W-1:0] data_value,
   input  logic        [cptep_pkg::COV_W-1:0]  coverage_value,
   output logic signed [cptep_pkg::DATA_W-1:0] data_out
);

   localparam int PROD_W = cptep_pkg::DATA_W + cptep_pkg::COV_W;

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] scaled;

   // Signed data times unsigned coverage, zero extended to keep its sign off.
   assign product_in = PROD_W'(data_value) * $signed({1'b0, coverage_value});

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // Round to nearest with halves upwards, drop 16 fraction bits, saturate.
   // A zero coverage gives a zero product, which rounds to zero.
   assign rounded = product_ff + PROD_W'(32768);
   assign scaled  = rounded >>> 16;

   always_comb begin
      if (scaled > PROD_W'(32'sh7FFF_FFFF)) begin
         data_out = 32'sh7FFF_FFFF;
      end else if (scaled < -PROD_W'(33'sh0_8000_0000)) begin
         data_out = 32'sh8000_0000;
      end else begin
         data_out = scaled[cptep_pkg::DATA_W-1:0];
      end
   end

endmodule

>>> hdl/coverage_premultiply_tile_edge_pad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_premultiply_tile_edge_pad
// Tile packer storing coverage-premultiplied texels with clamp-to-edge reads.
// ----------------------------------------------------------------------------
// A load beat (tuser 0) writes one texel, premultiplied by its saturated
// coverage, into a TILE_DIM x TILE_DIM RAM; a read beat (tuser 1) returns the
// texel at its coordinates clamped to the last configured region column and
// row; a fail beat (tuser 2) makes reads return zeros until the next load.
// Loads are taken one per cycle while no read holds the request port, and
// are written in the cycle after acceptance. A read passes through the
// first stage, the RAM read stage and the response register in that order
// and occupies all three: the next request is taken once the response
// has been taken or is being taken. The RAM is not cleared after reset;
// every texel of the region must be loaded before it is read.
// ----------------------------------------------------------------------------
module coverage_premultiply_tile_edge_pad #(
   parameter int TILE_DIM = cptep_pkg::TILE_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = texel_x[5:0], texel_y[11:6], data_value[43:12],
   // coverage_value[60:44], zero pad; tuser = operation[1:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   // Response: tdata = data_out[31:0], coverage_out[48:32], zero pad.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // Configuration write: index 0 region_width, index 1 region_height.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   localparam int TEXELS = TILE_DIM * TILE_DIM;
   localparam int AW     = (TEXELS > 1) ? $clog2(TEXELS) : 1;
   localparam int CW     = ($clog2(TILE_DIM) + 1 > 8) ? $clog2(TILE_DIM) + 1 : 8;
   localparam int DW     = cptep_pkg::DATA_W;
   localparam int VW     = cptep_pkg::COV_W;
   localparam logic [CW-1:0] LAST = CW'(TILE_DIM - 1);

   // Request fields.
   logic [cptep_pkg::COORD_W-1:0] texel_x;
   logic [cptep_pkg::COORD_W-1:0] texel_y;
   logic signed [DW-1:0]          data_value;
   logic [VW-1:0]                 coverage_value;
   logic [cptep_pkg::OP_W-1:0]    operation;

   assign texel_x        = req_tdata[5:0];
   assign texel_y        = req_tdata[11:6];
   assign data_value     = req_tdata[43:12];
   assign coverage_value = req_tdata[60:44];
   assign operation      = req_tuser;

   // Registers.
   logic [cptep_pkg::REGION_W-1:0] region_width_ff;
   logic [cptep_pkg::REGION_W-1:0] region_height_ff;
   logic                           zero_tile_ff;
   logic                           zero_tile_in;
   cptep_pkg::stage_type           s1_ff;
   cptep_pkg::stage_type           s1_in;
   cptep_pkg::stage_type           s2_ff;
   logic [AW-1:0]                  addr_ff;
   logic [AW-1:0]                  addr_in;
   logic [VW-1:0]                  cov_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [DW-1:0]                  rsp_data_ff;
   logic [VW-1:0]                  rsp_cov_ff;

   logic                   accept;
   logic [VW-1:0]          cov_sat;
   logic [CW-1:0]          x_ext;
   logic [CW-1:0]          y_ext;
   logic [CW-1:0]          lim_x;
   logic [CW-1:0]          lim_y;
   logic [CW-1:0]          cx;
   logic [CW-1:0]          cy;
   logic [CW-1:0]          ax;
   logic [CW-1:0]          ay;
   logic [2*CW-1:0]        index;
   logic                   in_tile;
   logic signed [DW-1:0]   premul_data;
   logic [DW+VW-1:0]       rd_entry;

   // Configuration port is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_width_ff  <= 7'd64;
         region_height_ff <= 7'd64;
      end else if (csr_valid) begin
         unique case (csr_index)
            cptep_pkg::REG_REGION_WIDTH:  region_width_ff  <= csr_data;
            cptep_pkg::REG_REGION_HEIGHT: region_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // A new request is taken unless a read is still on its way out.
   assign req_tready = !s1_ff.read && !s2_ff.read && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Clamp limits: a zero size acts as one, and the tile edge bounds both.
   always_comb begin
      lim_x = (region_width_ff == '0) ? '0 : CW'(region_width_ff - 7'd1);
      lim_y = (region_height_ff == '0) ? '0 : CW'(region_height_ff - 7'd1);
      if (lim_x > LAST) begin
         lim_x = LAST;
      end
      if (lim_y > LAST) begin
         lim_y = LAST;
      end
   end

   assign x_ext   = CW'(texel_x);
   assign y_ext   = CW'(texel_y);
   assign cx      = (x_ext > lim_x) ? lim_x : x_ext;
   assign cy      = (y_ext > lim_y) ? lim_y : y_ext;
   assign in_tile = (x_ext <= LAST) && (y_ext <= LAST);
   assign cov_sat = (coverage_value > cptep_pkg::COV_ONE) ? cptep_pkg::COV_ONE
                                                          : coverage_value;

   // Address: loads use raw coordinates, reads the clamped ones.
   always_comb begin
      if (operation == cptep_pkg::OP_READ) begin
         ax = cx;
         ay = cy;
      end else begin
         ax = x_ext;
         ay = y_ext;
      end
      index   = (2*CW)'(ay) * (2*CW)'(TILE_DIM) + (2*CW)'(ax);
      addr_in = index[AW-1:0];
   end

   // Decode the accepted beat into the first stage and the fail flag.
   always_comb begin
      s1_in        = '0;
      zero_tile_in = zero_tile_ff;
      if (accept) begin
         case (operation)
            cptep_pkg::OP_LOAD: begin
               s1_in.load   = in_tile;
               zero_tile_in = 1'b0;
            end
            cptep_pkg::OP_READ: begin
               s1_in.read = 1'b1;
               s1_in.zero = zero_tile_ff;
            end
            cptep_pkg::OP_FAIL: begin
               zero_tile_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         zero_tile_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s1_ff;
         zero_tile_ff <= zero_tile_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= addr_in;
         cov_ff  <= cov_sat;
      end
   end

   // Product registered inside; rounded result ready in the first stage.
   cptep_premul u_premul (
      .clock          (clock),
      .data_value     (data_value),
      .coverage_value (cov_sat),
      .data_out       (premul_data)
   );

   // Tile store: loads write and reads fetch from the first stage, in order.
   cptep_ram #(
      .WIDTH (cptep_pkg::ENTRY_W),
      .DEPTH (TEXELS)
   ) u_tile_store (
      .clock   (clock),
      .wr_en   (s1_ff.load),
      .wr_addr (addr_ff),
      .wr_data ({cov_ff, premul_data}),
      .rd_en   (s1_ff.read),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   // Response register, loaded when the fetched texel arrives.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_ff.read) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ff.read) begin
         rsp_data_ff <= s2_ff.zero ? '0 : rd_entry[DW-1:0];
         rsp_cov_ff  <= s2_ff.zero ? '0 : rd_entry[DW+VW-1:DW];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cov_ff, rsp_data_ff};

endmodule
